>>> hw/rtl/mes_pkg.sv
// Package for the merge-exchange sorter: payload structs, record type and sizes.
// Used by merge_exchange_sort_dummy_last; depends on nothing else.
package mes_pkg;

   localparam int MAX_ITEMS_DEFAULT = 64;
   localparam int KEY_W             = 32;
   localparam int TAG_W             = 32;

   typedef struct packed {
      logic signed [KEY_W-1:0] sort_key;
      logic                    is_dummy;
      logic [TAG_W-1:0]        record_tag;
      logic                    last_in;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] out_key;
      logic                    out_dummy;
      logic [TAG_W-1:0]        out_tag;
      logic                    last_out;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic                    dummy;
      logic [TAG_W-1:0]        tag;
   } rec_type;

endpackage

>>> hw/rtl/merge_exchange_sort_dummy_last.sv
// Merge-exchange sorter top level: record store, comparator and loop sequencer.
// Depends on mes_pkg for payload types and default sizes.
//
// Usage: records arrive on the req_ channel (valid/ready) and are stored in
// order. The record with last_in set closes the set; records beyond
// MAX_ITEMS are dropped, but a dropped last_in still closes the set.
// The block then sorts the set in place with Batcher's merge-exchange network,
// one compare-exchange at a time through a single comparator and a memory
// with two read ports and one write port, and sends the records out on the
// rsp_ channel from the end of the sorted set back to its start: keys
// descending, real records before dummies among equal keys. last_out marks
// the final record. req_ready is high only while loading.
// Work for a set of n records: each record is written to the store as it is
// accepted, setup doubles p up to the largest power of two below n, each
// network pass scans its candidate indices and then closes, each comparator
// actually evaluated reads both records and compares them, and a swap writes
// the two records in turn through the single write port; each result is then
// read from memory and loaded into the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset empties the set and clears the output valid; store contents are kept.
module merge_exchange_sort_dummy_last #(
   parameter int MAX_ITEMS = mes_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mes_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = AW + 1;

   typedef enum logic [6:0] {
      ST_LOAD    = 7'b0000001,
      ST_SETUP   = 7'b0000010,
      ST_SCAN    = 7'b0000100,
      ST_CMP     = 7'b0001000,
      ST_WRJ     = 7'b0010000,
      ST_EMIT_RD = 7'b0100000,
      ST_EMIT_LD = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [CW-1:0]    e_ff, e_in;
   logic [AW-1:0]    p_ff, p_in;
   logic [AW-1:0]    ptop_ff, ptop_in;
   logic [AW-1:0]    q_ff, q_in;
   logic [AW-1:0]    r_ff, r_in;
   logic [AW-1:0]    d_ff, d_in;
   logic [AW-1:0]    i_ff, i_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mes_pkg::rsp_type rsp_data_ff, rsp_data_in;

   mes_pkg::rec_type mem [MAX_ITEMS];
   mes_pkg::rec_type rd_a_ff, rd_b_ff;
   mes_pkg::rec_type wr_data;
   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;

   logic [CW-1:0]    sum_id;
   logic [AW-1:0]    j_addr;
   logic [CW-1:0]    n_load;
   logic [CW-1:0]    p_dbl;
   logic [AW-1:0]    d_next;
   logic [AW-1:0]    p_half;
   logic             swap;
   logic             req_accept;
   logic             rsp_free;

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign sum_id = {1'b0, i_ff} + {1'b0, d_ff};
   assign j_addr = sum_id[AW-1:0];
   assign p_dbl  = {p_ff, 1'b0};
   assign d_next = q_ff - p_ff;
   assign p_half = p_ff >> 1;

   // Exchange when the later key is smaller, or on equal keys when a real
   // record sits ahead of a dummy.
   always_comb begin
      if (rd_b_ff.key == rd_a_ff.key) begin
         swap = !rd_a_ff.dummy && rd_b_ff.dummy;
      end else begin
         swap = rd_b_ff.key < rd_a_ff.key;
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      e_in         = e_ff;
      p_in         = p_ff;
      ptop_in      = ptop_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      i_in         = i_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff;
      wr_data      = '{key: req_data.sort_key, dummy: req_data.is_dummy,
                       tag: req_data.record_tag};
      rd_en        = 1'b0;
      rd_addr_a    = i_ff;
      rd_addr_b    = j_addr;
      n_load       = n_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (n_ff < CW'(MAX_ITEMS)) begin
               n_load = n_ff + 1'b1;
            end
            if (req_accept) begin
               if (n_ff < CW'(MAX_ITEMS)) begin
                  wr_en   = 1'b1;
                  wr_addr = n_ff[AW-1:0];
               end
               n_in = n_load;
               if (req_data.last_in) begin
                  if (n_load == CW'(1)) begin
                     e_in     = n_load;
                     state_in = ST_EMIT_RD;
                  end else begin
                     p_in     = AW'(1);
                     state_in = ST_SETUP;
                  end
               end
            end
         end
         ST_SETUP: begin
            // find the largest power of two below n
            if (p_dbl < n_ff) begin
               p_in = p_dbl[AW-1:0];
            end else begin
               ptop_in  = p_ff;
               q_in     = p_ff;
               r_in     = '0;
               d_in     = p_ff;
               i_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sum_id >= n_ff) begin
               // end of pass: next d, or next p
               if (d_next != '0) begin
                  d_in = d_next;
                  q_in = q_ff >> 1;
                  r_in = p_ff;
                  i_in = '0;
               end else if (p_half == '0) begin
                  e_in     = n_ff;
                  state_in = ST_EMIT_RD;
               end else begin
                  p_in = p_half;
                  q_in = ptop_ff;
                  r_in = '0;
                  d_in = p_half;
                  i_in = '0;
               end
            end else if ((i_ff & p_ff) == r_ff) begin
               rd_en    = 1'b1;
               state_in = ST_CMP;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_CMP: begin
            if (swap) begin
               wr_en    = 1'b1;
               wr_addr  = i_ff;
               wr_data  = rd_b_ff;
               state_in = ST_WRJ;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_WRJ: begin
            wr_en    = 1'b1;
            wr_addr  = j_addr;
            wr_data  = rd_a_ff;
            i_in     = i_ff + 1'b1;
            state_in = ST_SCAN;
         end
         ST_EMIT_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = AW'(e_ff - 1'b1);
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_key: rd_a_ff.key, out_dummy: rd_a_ff.dummy,
                                out_tag: rd_a_ff.tag, last_out: e_ff == CW'(1)};
               e_in         = e_ff - 1'b1;
               if (e_ff == CW'(1)) begin
                  n_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      p_ff        <= p_in;
      ptop_ff     <= ptop_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      d_ff        <= d_in;
      i_ff        <= i_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

endmodule
